FILE: rtl/core/dbgr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dbgr_pkg: shared types and constants for the dB gain block
// widths of the fields, gain table entry, state codes and the dB step table
// ----------------------------------------------------------------------------
package dbgr_pkg;

  localparam int CHANNELS_DEF = 8;

  localparam int SMP_W      = 24;
  localparam int DB_W       = 12;
  localparam int CH_IN_W    = 3;
  localparam int BS_W       = 11;
  localparam int MB_W       = 10;
  localparam int GAIN_W     = 48;
  localparam int TGT_W      = 32;
  localparam int STEP_W     = 48;
  localparam int GAIN_SHIFT = 15;
  localparam int N_W        = BS_W + MB_W;
  localparam int ATT_N      = 12;
  localparam int ATT_IW     = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  localparam logic signed [DB_W-1:0] MAX_DB16     = 12'sd800;
  localparam logic [TGT_W-1:0]       TOP_GAIN_Q23 = 32'd2652710768;
  localparam logic [GAIN_W-1:0]      GAIN_MAX     = {1'b0, {(GAIN_W-1){1'b1}}};

  localparam logic [BS_W-1:0]        BS_RESET   = 11'd64;
  localparam logic [MB_W-1:0]        MB_RESET   = 10'd0;
  localparam logic signed [DB_W-1:0] MUTE_RESET = -12'sd1920;

  typedef enum logic {
    ACT_SAMPLE = 1'b0,
    ACT_SET    = 1'b1
  } action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BLOCK_SIZE   = 2'd0,
    CFG_MORPH_BLOCKS = 2'd1,
    CFG_MUTE_DB      = 2'd2
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_CH_RD,
    ST_CH_CALC,
    ST_CH_DIV,
    ST_SMP_UPD,
    ST_SMP_MUL,
    ST_SMP_OUT
  } state_t;

  // one channel entry of the gain memory
  typedef struct packed {
    logic [GAIN_W-1:0]        cur;
    logic [TGT_W-1:0]         tgt;
    logic signed [STEP_W-1:0] step;
  } ent_t;

  // address width of a channel memory
  function automatic int ch_w_of(input int n);
    ch_w_of = (n > 1) ? $clog2(n) : 1;
  endfunction

  // linear Q9.23 target placed in the Q10.38 gain format
  function automatic logic [GAIN_W-1:0] tgt_to_gain(input logic [TGT_W-1:0] t);
    tgt_to_gain = {1'b0, t, {GAIN_SHIFT{1'b0}}};
  endfunction

  // 10^(-2^i/320) in Q0.32
  function automatic logic [TGT_W-1:0] atten_f(input logic [ATT_IW-1:0] i);
    case (i)
      4'd0:    atten_f = 32'd4264173445;
      4'd1:    atten_f = 32'd4233600378;
      4'd2:    atten_f = 32'd4173110276;
      4'd3:    atten_f = 32'd4054710589;
      4'd4:    atten_f = 32'd3827893632;
      4'd5:    atten_f = 32'd3411613790;
      4'd6:    atten_f = 32'd2709941160;
      4'd7:    atten_f = 32'd1709857278;
      4'd8:    atten_f = 32'd680706443;
      4'd9:    atten_f = 32'd107884701;
      4'd10:   atten_f = 32'd2709941;
      4'd11:   atten_f = 32'd1710;
      default: atten_f = '0;
    endcase
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/dbgr_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dbgr_if: request channels of the dB gain block
// input items, output samples and register writes, each valid/ready
// ----------------------------------------------------------------------------
interface dbgr_in_if
  import dbgr_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic                     action;
  logic [CH_IN_W-1:0]       channel;
  logic                     apply_all;
  logic signed [DB_W-1:0]   gain_db;
  logic signed [SMP_W-1:0]  sample_in;
  logic                     block_end;

  modport source (output valid, action, channel, apply_all, gain_db, sample_in, block_end,
                  input ready);
  modport sink (input valid, action, channel, apply_all, gain_db, sample_in, block_end,
                output ready);
endinterface

interface dbgr_out_if
  import dbgr_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic signed [SMP_W-1:0] sample_out;
  logic [CH_IN_W-1:0]      channel_out;

  modport source (output valid, sample_out, channel_out, input ready);
  modport sink (input valid, sample_out, channel_out, output ready);
endinterface

interface dbgr_cfg_if
  import dbgr_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/dbgr_mem.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dbgr_mem: per-channel gain memory
// one write and one registered read port, entries read as zero until written
// ----------------------------------------------------------------------------
module dbgr_mem
  import dbgr_pkg::*;
#(
  parameter int CHANNELS = CHANNELS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   rd_en,
  input  logic [ch_w_of(CHANNELS)-1:0] rd_addr,
  input  logic                   wr_en,
  input  logic [ch_w_of(CHANNELS)-1:0] wr_addr,
  input  ent_t                   wr_data,
  output ent_t                   rd_data
);
  ent_t                mem_r [CHANNELS];
  logic [CHANNELS-1:0] valid_r;
  ent_t                rdata_r;
  logic                rvalid_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_r <= mem_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rvalid_r <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rvalid_r <= valid_r[rd_addr];
      end
    end
  end

  assign rd_data = rvalid_r ? rdata_r : '0;

endmodule
`default_nettype wire

FILE: rtl/core/dbgr_db2lin.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dbgr_db2lin: dB to linear gain converter
// clips the request, then one table multiply per exponent bit and the +50 dB scale, in successive cycles
// ----------------------------------------------------------------------------
module dbgr_db2lin
  import dbgr_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic signed [DB_W-1:0] gain_db,
  input  logic signed [DB_W-1:0] mute_db,
  output logic                   done,
  output logic [TGT_W-1:0]       target
);
  localparam int V_W = TGT_W + 1;
  localparam int P_W = V_W + TGT_W;

  logic signed [DB_W-1:0] c_lo;
  logic signed [DB_W-1:0] c_clip;
  logic signed [DB_W:0]   e_wide;
  logic                   is_zero;
  logic [TGT_W-1:0]       mul_b;
  logic [P_W-1:0]         prod;
  logic [P_W-1:0]         prod_rnd;
  logic [V_W-1:0]         v_new;

  logic                   busy_r;
  logic                   done_r;
  logic [ATT_IW-1:0]      i_r;
  logic [DB_W-1:0]        e_r;
  logic                   zero_r;
  logic [V_W-1:0]         v_r;
  logic [TGT_W-1:0]       t_r;

  always_comb begin
    c_lo    = (gain_db < mute_db) ? mute_db : gain_db;
    c_clip  = (c_lo > MAX_DB16) ? MAX_DB16 : c_lo;
    is_zero = (c_clip <= mute_db);
    e_wide  = {MAX_DB16[DB_W-1], MAX_DB16} - {c_clip[DB_W-1], c_clip};
  end

  // one shared multiplier: table factor per bit, then the +50 dB scale
  assign mul_b    = (i_r == ATT_IW'(ATT_N)) ? TOP_GAIN_Q23 : atten_f(i_r);
  assign prod     = P_W'(v_r) * P_W'(mul_b);
  assign prod_rnd = prod + (P_W'(1) << (TGT_W - 1));
  assign v_new    = prod_rnd[P_W-1:TGT_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && (i_r == ATT_IW'(ATT_N))) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      i_r    <= '0;
      e_r    <= e_wide[DB_W-1:0];
      zero_r <= is_zero;
      v_r    <= V_W'(1) << TGT_W;
    end else if (busy_r) begin
      if (i_r == ATT_IW'(ATT_N)) begin
        t_r <= zero_r ? '0 : v_new[TGT_W-1:0];
      end else begin
        if (e_r[i_r]) begin
          v_r <= v_new;
        end
        i_r <= i_r + 1'b1;
      end
    end
  end

  assign done   = done_r;
  assign target = t_r;

endmodule
`default_nettype wire

FILE: rtl/core/dbgr_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dbgr_div: serial signed divider for the ramp step
// restoring, one quotient bit per cycle, truncates toward zero
// ----------------------------------------------------------------------------
module dbgr_div
  import dbgr_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic signed [STEP_W-1:0] dividend,
  input  logic [N_W-1:0]           divisor,
  output logic                     done,
  output logic signed [STEP_W-1:0] quotient
);
  localparam int MAG_W = STEP_W - 1;
  localparam int CNT_W = $clog2(MAG_W + 1);

  logic [STEP_W-1:0] dvd_abs;
  logic [N_W:0]      shl;
  logic              ge;

  logic              busy_r;
  logic              done_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [N_W:0]      rem_r;
  logic [MAG_W-1:0]  quo_r;
  logic [N_W-1:0]    dvs_r;
  logic              neg_r;

  assign dvd_abs = dividend[STEP_W-1] ? -dividend : dividend;
  assign shl     = {rem_r[N_W-1:0], quo_r[MAG_W-1]};
  assign ge      = (shl >= {1'b0, dvs_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && (cnt_r == CNT_W'(1))) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg_r <= dividend[STEP_W-1];
      quo_r <= dvd_abs[MAG_W-1:0];
      rem_r <= '0;
      dvs_r <= divisor;
      cnt_r <= CNT_W'(MAG_W);
    end else if (busy_r) begin
      rem_r <= ge ? (shl - {1'b0, dvs_r}) : shl;
      quo_r <= {quo_r[MAG_W-2:0], ge};
      cnt_r <= cnt_r - 1'b1;
    end
  end

  assign done     = done_r;
  assign quotient = neg_r ? -{1'b0, quo_r} : {1'b0, quo_r};

endmodule
`default_nettype wire

FILE: rtl/core/db_gain_with_linear_ramp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// db_gain_with_linear_ramp: multichannel dB gain with linear ramping
// gain, target and step of every channel live in one memory entry
// ----------------------------------------------------------------------------
// sample request: gain read, ramp update, multiply, then the output register when it is free; next accept from idle
// a block end that finishes a ramp adds a snap pass that reads and rewrites every channel
// set request: dB conversion, then a read and a write per channel when immediate,
//   or a read, a step from the bit-serial divider and a write per channel when ramping
// reset (synchronous, active low) clears control state and the entry valid bits;
//   an entry not yet written reads as zero gain, zero target, zero step
module db_gain_with_linear_ramp
  import dbgr_pkg::*;
#(
  parameter int CHANNELS = CHANNELS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  dbgr_in_if.sink    in_ch,
  dbgr_out_if.source out_ch,
  dbgr_cfg_if.sink   cfg_ch
);
  localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int FRAC   = SMP_W - 1;
  localparam int GM_W   = GAIN_W - GAIN_SHIFT;
  localparam int PROD_W = SMP_W + GM_W + 1;
  localparam int RND_W  = PROD_W + 1 - FRAC;

  // configuration registers
  logic [BS_W-1:0]        bs_r;
  logic [MB_W-1:0]        mb_r;
  logic signed [DB_W-1:0] mute_r;

  // control state
  state_t                 state_r;
  state_t                 state_nxt;
  logic [MB_W-1:0]        ramp_r;
  logic [CH_W-1:0]        idx_r;
  logic                   snap_r;
  logic                   out_valid_r;

  // request and datapath registers
  logic [CH_IN_W-1:0]       ch_r;
  logic                     all_r;
  logic signed [SMP_W-1:0]  smp_r;
  logic                     bend_r;
  logic [N_W-1:0]           n_r;
  logic [TGT_W-1:0]         t_r;
  logic [GAIN_W-1:0]        cur_h_r;
  logic [TGT_W-1:0]         tgt_h_r;
  logic [GM_W-1:0]          gmul_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [SMP_W-1:0]  out_smp_r;
  logic [CH_IN_W-1:0]       out_ch_r;

  // handshake and control
  logic in_acc;
  logic present_in;
  logic out_free;
  logic last_ch;
  logic ch_hit;
  logic idx_adv;
  logic out_load;

  // memory port
  logic            mem_rd;
  logic [CH_W-1:0] mem_rd_addr;
  logic            mem_wr;
  logic [CH_W-1:0] mem_wr_addr;
  ent_t            mem_wr_data;
  ent_t            rd;

  // converter and divider
  logic                     conv_start;
  logic                     conv_done;
  logic [TGT_W-1:0]         conv_t;
  logic                     div_start;
  logic                     div_done;
  logic signed [STEP_W-1:0] div_q;

  // datapath signals
  logic [BS_W-1:0]          bs_eff;
  logic [TGT_W-1:0]         tgt_new;
  logic signed [GAIN_W:0]   diff;
  logic signed [GAIN_W+1:0] g_sum;
  logic [GAIN_W-1:0]        g_new;
  logic [PROD_W:0]          rsum;
  logic signed [RND_W-1:0]  rnd;
  logic [RND_W-FRAC-1:0]    rnd_hi;
  logic signed [SMP_W-1:0]  res_sat;

  // register writes are taken every cycle
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bs_r   <= BS_RESET;
      mb_r   <= MB_RESET;
      mute_r <= MUTE_RESET;
    end else if (cfg_ch.valid) begin
      case (cfg_idx_t'(cfg_ch.index))
        CFG_BLOCK_SIZE:   bs_r   <= cfg_ch.data[BS_W-1:0];
        CFG_MORPH_BLOCKS: mb_r   <= cfg_ch.data[MB_W-1:0];
        CFG_MUTE_DB:      mute_r <= $signed(cfg_ch.data[DB_W-1:0]);
        default: ;
      endcase
    end
  end

  // one request at a time, the result register parts us from the sink
  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign present_in  = (32'(in_ch.channel) < CHANNELS);
  assign out_free    = !out_valid_r || out_ch.ready;
  assign last_ch     = (idx_r == CH_W'(CHANNELS - 1));
  assign ch_hit      = all_r || (32'(idx_r) == 32'(ch_r));
  assign bs_eff      = (bs_r == '0) ? BS_W'(1) : bs_r;

  dbgr_mem #(
    .CHANNELS (CHANNELS)
  ) u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (mem_rd),
    .rd_addr (mem_rd_addr),
    .wr_en   (mem_wr),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_data (rd)
  );

  dbgr_db2lin u_db2lin (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (conv_start),
    .gain_db (in_ch.gain_db),
    .mute_db (mute_r),
    .done    (conv_done),
    .target  (conv_t)
  );

  dbgr_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (diff[STEP_W-1:0]),
    .divisor  (n_r),
    .done     (div_done),
    .quotient (div_q)
  );

  // new target of the swept channel and the distance still to ramp
  always_comb begin
    tgt_new = ch_hit ? t_r : rd.tgt;
    diff    = $signed({2'b00, tgt_new, {GAIN_SHIFT{1'b0}}}) - $signed({1'b0, rd.cur});
  end

  // ramp step on a sample while a ramp is running, clamped to the gain range
  always_comb begin
    g_sum = $signed({2'b00, rd.cur}) + $signed({{2{rd.step[STEP_W-1]}}, rd.step});
    if (ramp_r == '0) begin
      g_new = rd.cur;
    end else if (g_sum < 0) begin
      g_new = '0;
    end else if (g_sum > $signed({2'b00, GAIN_MAX})) begin
      g_new = GAIN_MAX;
    end else begin
      g_new = g_sum[GAIN_W-1:0];
    end
  end

  // round half up, then saturate to 24 bits
  always_comb begin
    rsum    = {prod_r[PROD_W-1], prod_r} + ((PROD_W + 1)'(1) << (FRAC - 1));
    rnd     = rsum[PROD_W:FRAC];
    rnd_hi  = rnd[RND_W-1:FRAC];
    if ((&rnd_hi) || !(|rnd_hi)) begin
      res_sat = rnd[SMP_W-1:0];
    end else if (rnd[RND_W-1]) begin
      res_sat = {1'b1, {(SMP_W-1){1'b0}}};
    end else begin
      res_sat = {1'b0, {(SMP_W-1){1'b1}}};
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_ch.action == ACT_SET) begin
            if (in_ch.apply_all || present_in) begin
              state_nxt = ST_CONV;
            end
          end else if (present_in) begin
            state_nxt = ST_SMP_UPD;
          end else begin
            state_nxt = ST_SMP_MUL;
          end
        end
      end
      ST_CONV: begin
        if (conv_done) begin
          state_nxt = ST_CH_RD;
        end
      end
      ST_CH_RD: begin
        state_nxt = ST_CH_CALC;
      end
      ST_CH_CALC: begin
        if (!snap_r && (mb_r != '0)) begin
          state_nxt = ST_CH_DIV;
        end else begin
          state_nxt = last_ch ? ST_IDLE : ST_CH_RD;
        end
      end
      ST_CH_DIV: begin
        if (div_done) begin
          state_nxt = last_ch ? ST_IDLE : ST_CH_RD;
        end
      end
      ST_SMP_UPD: begin
        state_nxt = ST_SMP_MUL;
      end
      ST_SMP_MUL: begin
        state_nxt = ST_SMP_OUT;
      end
      ST_SMP_OUT: begin
        if (out_free) begin
          // the block end that empties the ramp starts the snap pass
          state_nxt = (bend_r && (ramp_r == MB_W'(1))) ? ST_CH_RD : ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    mem_rd      = 1'b0;
    mem_rd_addr = idx_r;
    mem_wr      = 1'b0;
    mem_wr_addr = idx_r;
    mem_wr_data = rd;
    conv_start  = 1'b0;
    div_start   = 1'b0;
    idx_adv     = 1'b0;
    out_load    = 1'b0;
    case (state_r)
      ST_IDLE: begin
        mem_rd      = in_acc && (in_ch.action == ACT_SAMPLE);
        mem_rd_addr = CH_W'(in_ch.channel);
        conv_start  = in_acc && (in_ch.action == ACT_SET) && (in_ch.apply_all || present_in);
      end
      ST_CH_RD: begin
        mem_rd = 1'b1;
      end
      ST_CH_CALC: begin
        if (snap_r) begin
          // ramp finished: gain lands on the target, step kept
          mem_wr      = 1'b1;
          mem_wr_data = '{cur: tgt_to_gain(rd.tgt), tgt: rd.tgt, step: rd.step};
          idx_adv     = 1'b1;
        end else if (mb_r == '0) begin
          // immediate change
          mem_wr      = 1'b1;
          mem_wr_data = '{cur: tgt_to_gain(tgt_new), tgt: tgt_new, step: '0};
          idx_adv     = 1'b1;
        end else begin
          div_start = 1'b1;
        end
      end
      ST_CH_DIV: begin
        if (div_done) begin
          mem_wr      = 1'b1;
          mem_wr_data = '{cur: cur_h_r, tgt: tgt_h_r, step: div_q};
          idx_adv     = 1'b1;
        end
      end
      ST_SMP_UPD: begin
        mem_wr      = 1'b1;
        mem_wr_addr = CH_W'(ch_r);
        mem_wr_data = '{cur: g_new, tgt: rd.tgt, step: rd.step};
      end
      ST_SMP_OUT: begin
        out_load = out_free;
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ramp_r      <= '0;
      idx_r       <= '0;
      snap_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (conv_done) begin
        ramp_r <= mb_r;
        idx_r  <= '0;
        snap_r <= 1'b0;
      end
      if (idx_adv) begin
        idx_r <= last_ch ? '0 : idx_r + 1'b1;
      end
      if (out_load && bend_r && (ramp_r != '0)) begin
        ramp_r <= ramp_r - 1'b1;
        if (ramp_r == MB_W'(1)) begin
          snap_r <= 1'b1;
          idx_r  <= '0;
        end
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      ch_r   <= in_ch.channel;
      all_r  <= in_ch.apply_all;
      smp_r  <= in_ch.sample_in;
      bend_r <= in_ch.block_end;
      n_r    <= N_W'(mb_r) * N_W'(bs_eff);
      if (!present_in) begin
        gmul_r <= '0;
      end
    end
    if (conv_done) begin
      t_r <= conv_t;
    end
    if (div_start) begin
      cur_h_r <= rd.cur;
      tgt_h_r <= tgt_new;
    end
    if (state_r == ST_SMP_UPD) begin
      gmul_r <= g_new[GAIN_W-1:GAIN_SHIFT];
    end
    if (state_r == ST_SMP_MUL) begin
      prod_r <= smp_r * $signed({1'b0, gmul_r});
    end
    if (out_load) begin
      out_smp_r <= res_sat;
      out_ch_r  <= ch_r;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.sample_out  = out_smp_r;
  assign out_ch.channel_out = out_ch_r;

`ifndef SYNTHESIS
  // the ramp count only moves down, except when a set request reloads it
  a_ramp_down: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_CONV) |=> (ramp_r <= $past(ramp_r)))
    else $error("ramp count rose outside a gain change");

  // read and write never meet on one entry in the same cycle
  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_rd && mem_wr && (mem_rd_addr == mem_wr_addr)))
    else $error("gain memory read and write to one entry");

  // a step is delivered only while the sweep waits for it
  a_div_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == ST_CH_DIV))
    else $error("divider finished outside the step wait");

  // a converted target arrives only while a set request waits for it
  a_conv_state: assert property (@(posedge clk) disable iff (!rst_n)
    conv_done |-> (state_r == ST_CONV))
    else $error("dB conversion finished outside a set request");
`endif

endmodule
`default_nettype wire

FILE: tb/db_gain_with_linear_ramp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// db_gain_with_linear_ramp_checker: gain predictor and output comparison
// watches the request channels, keeps its own gain state, checks each output
// ----------------------------------------------------------------------------
module db_gain_with_linear_ramp_checker
  import dbgr_pkg::*;
#(
  parameter int NCH = CHANNELS_DEF
) (
  input  logic   clk,
  input  logic   rst_n,
  dbgr_in_if     in_mon,
  dbgr_out_if    out_mon,
  dbgr_cfg_if    cfg_mon,
  output int     err_count,
  output int     pending
);

  typedef struct {
    logic signed [SMP_W-1:0] smp;
    logic [CH_IN_W-1:0]      ch;
  } gained_t;

  localparam logic [31:0] ATTEN_TAB [12] = '{
    32'd4264173445, 32'd4233600378, 32'd4173110276, 32'd4054710589,
    32'd3827893632, 32'd3411613790, 32'd2709941160, 32'd1709857278,
    32'd680706443, 32'd107884701, 32'd2709941, 32'd1710
  };

  gained_t     gained_q[$];
  int          blk_sz;
  int          morph;
  int          mute;
  logic [47:0] gain_cur [NCH];
  logic [31:0] gain_tgt [NCH];
  longint      gain_inc [NCH];
  int          ramp_left;

  assign pending = gained_q.size();

  task automatic report(input string what);
    err_count++;
    if (err_count <= 20) $display("mismatch at %0t: %s", $realtime, what);
  endtask

  function automatic logic [31:0] lin_target(input int d);
    int          c;
    int          e;
    logic [63:0] v;
    c = (d < mute) ? mute : d;
    if (c > 800) c = 800;
    if (c <= mute) return 32'd0;
    e = 800 - c;
    v = 64'h1_0000_0000;
    for (int i = 0; i < 12; i++)
      if (e[i]) v = (v * ATTEN_TAB[i] + 64'h8000_0000) >> 32;
    return 32'((v * 64'(TOP_GAIN_Q23) + 64'h8000_0000) >> 32);
  endfunction

  task automatic snap_gains();
    for (int c = 0; c < NCH; c++) gain_cur[c] = {1'b0, gain_tgt[c], 15'b0};
  endtask

  task automatic apply_set(input logic [2:0] ch, input logic all,
                           input logic signed [11:0] db);
    logic [31:0] t;
    longint      n;
    t = lin_target(int'(db));
    for (int c = 0; c < NCH; c++)
      if (all || c == ch) gain_tgt[c] = t;
    if (morph > 0) begin
      n = longint'(morph) * longint'(blk_sz == 0 ? 1 : blk_sz);
      for (int c = 0; c < NCH; c++)
        gain_inc[c] = (longint'({1'b0, gain_tgt[c], 15'b0}) - longint'(gain_cur[c])) / n;
    end else begin
      for (int c = 0; c < NCH; c++) gain_inc[c] = 0;
      snap_gains();
    end
    ramp_left = morph;
  endtask

  task automatic apply_sample(input logic [2:0] ch, input logic signed [23:0] smp,
                              input logic bend);
    longint  g;
    longint  p;
    longint  r;
    gained_t x;
    if (ramp_left > 0) begin
      g = longint'(gain_cur[ch]) + gain_inc[ch];
      if (g < 0) g = 0;
      if (g > longint'(GAIN_MAX)) g = longint'(GAIN_MAX);
      gain_cur[ch] = 48'(g);
    end
    p = longint'(smp) * longint'(gain_cur[ch] >> 15);
    r = (p + (64'sd1 <<< 22)) >>> 23;
    if (r > 8388607) r = 8388607;
    if (r < -8388608) r = -8388608;
    x.smp = 24'(r);
    x.ch  = ch;
    gained_q.push_back(x);
    if (bend && ramp_left > 0) begin
      ramp_left--;
      if (ramp_left == 0) snap_gains();
    end
  endtask

  always @(posedge clk) begin
    gained_t exp_item;
    if (!rst_n) begin
      gained_q.delete();
      blk_sz    = int'(BS_RESET);
      morph     = int'(MB_RESET);
      mute      = int'(MUTE_RESET);
      ramp_left = 0;
      for (int c = 0; c < NCH; c++) begin
        gain_cur[c] = '0;
        gain_tgt[c] = '0;
        gain_inc[c] = 0;
      end
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (gained_q.size() == 0) begin
          report($sformatf("unexpected output %0d ch %0d", out_mon.sample_out,
                           out_mon.channel_out));
        end else begin
          exp_item = gained_q.pop_front();
          if (out_mon.sample_out !== exp_item.smp)
            report($sformatf("sample_out %0d, expected %0d", out_mon.sample_out,
                             exp_item.smp));
          if (out_mon.channel_out !== exp_item.ch)
            report($sformatf("channel_out %0d, expected %0d", out_mon.channel_out,
                             exp_item.ch));
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        if (in_mon.action == ACT_SET)
          apply_set(in_mon.channel, in_mon.apply_all, in_mon.gain_db);
        else
          apply_sample(in_mon.channel, in_mon.sample_in, in_mon.block_end);
      end
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          CFG_BLOCK_SIZE:   blk_sz = int'(cfg_mon.data[10:0]);
          CFG_MORPH_BLOCKS: morph  = int'(cfg_mon.data[9:0]);
          CFG_MUTE_DB:      mute   = int'($signed(cfg_mon.data));
          default: ;
        endcase
      end
    end
  end

  initial err_count = 0;

endmodule

FILE: tb/db_gain_with_linear_ramp_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// db_gain_with_linear_ramp_tb: stimulus and verdict for the dB gain block
// directed gain and sample requests, then random phases over several settings
// ----------------------------------------------------------------------------
module db_gain_with_linear_ramp_tb;
  import dbgr_pkg::*;

  localparam int LIMIT = 4000000;
  localparam int SETTLE = 700;     // longest set request plus snap pass, with margin

  logic clk;
  logic rst_n;
  int   cycles;
  int   errors;
  int   pending;
  int   n_smp;
  int   n_set;
  int   n_cfg;

  // idling control for both sides
  logic quiet;
  logic hold_trig;
  logic hold_seen;
  int   hold_cnt;

  dbgr_in_if  in_if();
  dbgr_out_if out_if();
  dbgr_cfg_if cfg_if();

  db_gain_with_linear_ramp u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  db_gain_with_linear_ramp_checker u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_mon    (in_if),
    .out_mon   (out_if),
    .cfg_mon   (cfg_if),
    .err_count (errors),
    .pending   (pending)
  );

  always #1 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Verification failed");
      $finish;
    end
  end

  // long hold-off of the receiver, counted here
  always @(posedge clk) begin
    if (hold_trig != hold_seen) begin
      hold_seen <= hold_trig;
      hold_cnt  <= 400;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
    end
  end

  // receiver ready: random stalls, none in quiet stretches, low while held off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else if (hold_cnt != 0) begin
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= quiet || ($urandom_range(0, 99) >= 19);
    end
  end

  // one request on the input channel; valid stays high after it unless the next request idles first
  task automatic send(input action_t act, input logic [2:0] ch, input logic all,
                      input logic [11:0] db, input logic [23:0] smp, input logic bend);
    if (!quiet && $urandom_range(0, 99) < 19) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_if.valid     <= 1'b1;
    in_if.action    <= act;
    in_if.channel   <= ch;
    in_if.apply_all <= all;
    in_if.gain_db   <= db;
    in_if.sample_in <= smp;
    in_if.block_end <= bend;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    if (act == ACT_SET) n_set++;
    else n_smp++;
  endtask

  // all results in, then let the block finish a set request or snap pass
  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [11:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.valid <= 1'b0;
    @(posedge clk);
    n_cfg++;
  endtask

  task automatic configure(input int bs, input int mb, input int mt);
    write_reg(CFG_BLOCK_SIZE, 12'(bs));
    write_reg(CFG_MORPH_BLOCKS, 12'(mb));
    write_reg(CFG_MUTE_DB, 12'(mt));
  endtask

  // random phase: mostly well formed blocks of round-robin samples with
  // occasional gain changes, plus some stray channels and stray block ends
  task automatic random_phase(input int items, input int bs);
    int blk;
    int pos;
    int r;
    logic [2:0] ch;
    logic bend;
    blk = (bs == 0) ? 1 : ((bs > 3) ? 3 : bs);
    pos = 0;
    for (int k = 0; k < items; k++) begin
      r = $urandom_range(0, 99);
      if (r < 12) begin
        // gain change, biased to the useful range but reaching the whole field
        if ($urandom_range(0, 3) == 0)
          send(ACT_SET, 3'($urandom), 1'($urandom), 12'($urandom), 24'($urandom),
               1'($urandom));
        else
          send(ACT_SET, 3'($urandom), 1'($urandom),
               12'($urandom_range(0, 1200) - 400), 24'($urandom), 1'($urandom));
      end else begin
        ch   = 3'(pos % 8);
        bend = (pos == blk * 8 - 1);
        if (r < 20) ch = 3'($urandom);
        if (r >= 20 && r < 26) bend = ~bend;
        send(ACT_SAMPLE, ch, 1'($urandom), 12'($urandom), 24'($urandom), bend);
        pos = (pos + 1) % (blk * 8);
      end
    end
  endtask

  initial begin
    int bs;
    clk = 1'b0;
    rst_n = 1'b0;
    cycles = 0;
    n_smp = 0;
    n_set = 0;
    n_cfg = 0;
    quiet = 1'b0;
    hold_trig = 1'b0;
    hold_seen = 1'b0;
    hold_cnt = 0;
    in_if.valid = 1'b0;
    in_if.action = ACT_SAMPLE;
    in_if.channel = '0;
    in_if.apply_all = 1'b0;
    in_if.gain_db = '0;
    in_if.sample_in = '0;
    in_if.block_end = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = CFG_BLOCK_SIZE;
    cfg_if.data = '0;
    out_if.ready = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed, reset settings: gains start muted
    send(ACT_SAMPLE, 3'd0, 1'b0, 12'd0, 24'h7FFFFF, 1'b1);   // block end with no ramp
    send(ACT_SET, 3'd0, 1'b1, 12'd800, 24'd0, 1'b1);         // all to +50 dB, block end ignored
    send(ACT_SAMPLE, 3'd0, 1'b0, 12'd0, 24'h7FFFFF, 1'b0);   // saturates high
    send(ACT_SAMPLE, 3'd7, 1'b0, 12'd0, 24'h800000, 1'b0);   // saturates low
    send(ACT_SAMPLE, 3'd3, 1'b0, 12'd0, 24'd1, 1'b0);
    send(ACT_SAMPLE, 3'd4, 1'b0, 12'd0, 24'hFFFFFF, 1'b0);
    send(ACT_SET, 3'd2, 1'b0, 12'h800, 24'd0, 1'b0);         // lowest dB, muted
    send(ACT_SAMPLE, 3'd2, 1'b0, 12'd0, 24'h7FFFFF, 1'b0);
    send(ACT_SET, 3'd5, 1'b0, 12'h7FF, 24'd0, 1'b0);         // above +50 dB, clipped
    send(ACT_SAMPLE, 3'd5, 1'b0, 12'd0, 24'h123456, 1'b0);
    send(ACT_SET, 3'd1, 1'b0, 12'd0, 24'd0, 1'b0);           // unity
    send(ACT_SAMPLE, 3'd1, 1'b0, 12'd0, 24'h800000, 1'b0);
    send(ACT_SET, 3'd6, 1'b0, 12'(-1920), 24'd0, 1'b0);      // exactly at mute
    send(ACT_SET, 3'd6, 1'b0, 12'(-1919), 24'd0, 1'b0);      // just above mute
    send(ACT_SAMPLE, 3'd6, 1'b0, 12'd0, 24'h7FFFFF, 1'b0);
    send(ACT_SAMPLE, 3'd0, 1'b0, 12'd0, 24'd0, 1'b0);
    drain();

    // ramping over one block of one sample, overshoot by extra samples
    configure(1, 1, -2048);
    send(ACT_SET, 3'd0, 1'b1, 12'd800, 24'd0, 1'b0);
    for (int c = 0; c < 8; c++) send(ACT_SAMPLE, 3'(c), 1'b0, 12'd0, 24'h7FFFFF, 1'b0);
    send(ACT_SET, 3'd0, 1'b1, 12'h800, 24'd0, 1'b0);
    send(ACT_SAMPLE, 3'd0, 1'b0, 12'd0, 24'h7FFFFF, 1'b0);
    send(ACT_SAMPLE, 3'd0, 1'b0, 12'd0, 24'h7FFFFF, 1'b0);   // ramps below zero
    send(ACT_SAMPLE, 3'd1, 1'b0, 12'd0, 24'h400000, 1'b1);   // ramp ends, snap
    send(ACT_SAMPLE, 3'd1, 1'b0, 12'd0, 24'h400000, 1'b0);
    drain();

    // random phases, the extremes of every register among them
    configure(2047, 1023, 0);
    random_phase(160, 2047);
    drain();

    configure(0, 3, -1920);
    hold_trig <= ~hold_trig;       // receiver backs off while requests keep coming
    random_phase(160, 0);
    drain();

    configure(4, 2, 2047);
    quiet <= 1'b1;                 // stretch with no idling on either side
    random_phase(160, 4);
    drain();
    quiet <= 1'b0;

    configure(1024, 0, -2048);
    random_phase(160, 1024);
    drain();

    for (int p = 0; p < 5; p++) begin
      bs = $urandom_range(0, 8);
      configure(bs, $urandom_range(0, 5), -$urandom_range(0, 2048));
      random_phase(150, bs);
      drain();
    end

    $display("checked %0d sample and %0d gain requests over %0d register writes",
             n_smp, n_set, n_cfg);
    $display("settings covered block sizes 0..2047, ramps 0..1023, mute -2048..2047");
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/dbgr_pkg.sv
rtl/core/dbgr_if.sv
rtl/core/dbgr_mem.sv
rtl/core/dbgr_db2lin.sv
rtl/core/dbgr_div.sv
rtl/core/db_gain_with_linear_ramp.sv
tb/db_gain_with_linear_ramp_checker.sv
tb/db_gain_with_linear_ramp_tb.sv
